### hw/rtl/xcfp_pkg.sv
// ----------------------------------------------------------------------------
// xcfp_pkg
// Shared codes and types of the xor checksum frame parser: byte classes,
// register indexes and the per-byte result record.
// ----------------------------------------------------------------------------
package xcfp_pkg;

  // byte classification codes
  localparam logic [3:0] CLS_IGNORED  = 4'd0;
  localparam logic [3:0] CLS_HEADER   = 4'd1;
  localparam logic [3:0] CLS_SIZE     = 4'd2;
  localparam logic [3:0] CLS_COMMAND  = 4'd3;
  localparam logic [3:0] CLS_ANSWER   = 4'd4;
  localparam logic [3:0] CLS_PAYLOAD  = 4'd5;
  localparam logic [3:0] CLS_CS_GOOD  = 4'd6;
  localparam logic [3:0] CLS_CS_BAD   = 4'd7;
  localparam logic [3:0] CLS_SIZE_ERR = 4'd8;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST_HEADER  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_HEADER = 8'd1;

  // header reset values
  localparam logic [7:0] REQUEST_HEADER_RST  = 8'hD9;
  localparam logic [7:0] RESPONSE_HEADER_RST = 8'h9D;

  // frame framing: header, size, type and checksum bytes
  localparam int unsigned MIN_FRAME = 4;
  // width of 4 + size for any size byte
  localparam int unsigned LEN_W = 9;

  // one classified byte
  typedef struct packed {
    logic [3:0] byte_class;
    logic       byte_direction;
    logic [7:0] byte_echo;
    logic [5:0] frame_offset;
    logic [6:0] frame_total;
    logic       frame_done;
    logic       frame_dropped;
  } result_t;

endpackage

### hw/rtl/xcfp_classifier.sv
// ----------------------------------------------------------------------------
// xcfp_classifier
// Combinational byte classifier: from the current frame state and one byte
// it forms the result record and the next frame state.
// ----------------------------------------------------------------------------
module xcfp_classifier #(
  parameter int unsigned MAX_FRAME = 64,
  parameter int unsigned POS_W     = 7
) (
  input  logic [7:0]       byte_value,
  input  logic             direction,
  input  logic [7:0]       request_header,
  input  logic [7:0]       response_header,
  input  logic [POS_W-1:0] position,
  input  logic             frame_direction,
  input  logic [POS_W-1:0] frame_length,
  input  logic [7:0]       running_xor,
  output logic [POS_W-1:0] position_nxt,
  output logic             frame_direction_nxt,
  output logic [POS_W-1:0] frame_length_nxt,
  output logic [7:0]       running_xor_nxt,
  output xcfp_pkg::result_t result
);

  localparam int unsigned EXT_W = (POS_W > 7) ? POS_W : 7;
  localparam logic [xcfp_pkg::LEN_W-1:0] MAX_LEN = xcfp_pkg::LEN_W'(MAX_FRAME);

  logic                       frame_open;
  logic                       same_dir;
  logic [POS_W-1:0]           pos_inc;
  logic [xcfp_pkg::LEN_W-1:0] size_len;
  logic [7:0]                 hdr;
  logic [7:0]                 xor_inc;
  logic [EXT_W-1:0]           offset_ext;
  logic [EXT_W-1:0]           total_ext;
  logic [EXT_W-1:0]           len_ext;

  // frame continuation or abandonment
  assign frame_open = (position != '0);
  assign same_dir   = frame_open && (frame_direction == direction);
  assign pos_inc    = same_dir ? (position + POS_W'(1)) : '0;
  assign xor_inc    = running_xor ^ byte_value;
  assign size_len   = xcfp_pkg::LEN_W'(byte_value) + xcfp_pkg::LEN_W'(xcfp_pkg::MIN_FRAME);
  assign hdr        = direction ? request_header : response_header;
  assign offset_ext = EXT_W'(pos_inc - POS_W'(1));
  assign len_ext    = EXT_W'(size_len);
  assign total_ext  = EXT_W'(frame_length);

  // classification and next state
  always_comb begin
    position_nxt          = '0;
    frame_direction_nxt   = 1'b0;
    frame_length_nxt      = '0;
    running_xor_nxt       = '0;
    result.byte_class     = xcfp_pkg::CLS_IGNORED;
    result.byte_direction = direction;
    result.byte_echo      = byte_value;
    result.frame_offset   = '0;
    result.frame_total    = '0;
    result.frame_done     = 1'b0;
    result.frame_dropped  = frame_open && !same_dir;

    if (!same_dir) begin
      // idle: look for this direction's header
      if (byte_value == hdr) begin
        position_nxt        = POS_W'(1);
        frame_direction_nxt = direction;
        running_xor_nxt     = byte_value;
        result.byte_class   = xcfp_pkg::CLS_HEADER;
      end
    end else begin
      result.frame_offset = offset_ext[5:0];
      if (pos_inc == POS_W'(2)) begin
        // size byte
        if (size_len > MAX_LEN) begin
          result.byte_class = xcfp_pkg::CLS_SIZE_ERR;
          result.frame_done = 1'b1;
        end else begin
          position_nxt        = pos_inc;
          frame_direction_nxt = frame_direction;
          running_xor_nxt     = xor_inc;
          frame_length_nxt    = size_len[POS_W-1:0];
          result.byte_class   = xcfp_pkg::CLS_SIZE;
          result.frame_total  = len_ext[6:0];
        end
      end else begin
        result.frame_total = total_ext[6:0];
        priority if (pos_inc == frame_length) begin
          // checksum byte closes the frame
          result.byte_class = (xor_inc == 8'd0) ? xcfp_pkg::CLS_CS_GOOD
                                                : xcfp_pkg::CLS_CS_BAD;
          result.frame_done = 1'b1;
        end else begin
          position_nxt        = pos_inc;
          frame_direction_nxt = frame_direction;
          running_xor_nxt     = xor_inc;
          frame_length_nxt    = frame_length;
          if (pos_inc == POS_W'(3)) begin
            result.byte_class = direction ? xcfp_pkg::CLS_COMMAND
                                          : xcfp_pkg::CLS_ANSWER;
          end else begin
            result.byte_class = xcfp_pkg::CLS_PAYLOAD;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/xor_checksum_frame_parser_core.sv
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_core
// Two-direction serial frame parser with XOR checksum, one result per byte.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one classification beat in the next cycle,
// held in an output register; a new byte is taken every cycle while that
// register is empty or being drained, so the sustained rate is one byte per
// clock, set by the frame state update (position, length,
// running xor). Payload is passed through byte by byte, not buffered: the
// consumer discards it when the checksum beat reports bad. Header bytes for
// each direction are set through the cfg_ write channel, which is always ready.
module xor_checksum_frame_parser_core #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input bytes
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte_value,
  input  logic                           in_direction,
  // classification results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     out_byte_class,
  output logic                           out_byte_direction,
  output logic [7:0]                     out_byte_echo,
  output logic [5:0]                     out_frame_offset,
  output logic [6:0]                     out_frame_total,
  output logic                           out_frame_done,
  output logic                           out_frame_dropped,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  localparam int unsigned POS_W = $clog2(MAX_FRAME + 1);

  logic [7:0]        req_hdr_r;
  logic [7:0]        rsp_hdr_r;
  logic [POS_W-1:0]  position_r;
  logic [POS_W-1:0]  position_nxt;
  logic              frame_dir_r;
  logic              frame_dir_nxt;
  logic [POS_W-1:0]  frame_len_r;
  logic [POS_W-1:0]  frame_len_nxt;
  logic [7:0]        run_xor_r;
  logic [7:0]        run_xor_nxt;
  logic              out_valid_r;
  xcfp_pkg::result_t result_r;
  xcfp_pkg::result_t result_nxt;
  logic              in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // header registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_hdr_r <= xcfp_pkg::REQUEST_HEADER_RST;
      rsp_hdr_r <= xcfp_pkg::RESPONSE_HEADER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == xcfp_pkg::REG_REQUEST_HEADER) begin
        req_hdr_r <= cfg_data;
      end
      if (cfg_index == xcfp_pkg::REG_RESPONSE_HEADER) begin
        rsp_hdr_r <= cfg_data;
      end
    end
  end

  xcfp_classifier #(
    .MAX_FRAME (MAX_FRAME),
    .POS_W     (POS_W)
  ) u_classifier (
    .byte_value          (in_byte_value),
    .direction           (in_direction),
    .request_header      (req_hdr_r),
    .response_header     (rsp_hdr_r),
    .position            (position_r),
    .frame_direction     (frame_dir_r),
    .frame_length        (frame_len_r),
    .running_xor         (run_xor_r),
    .position_nxt        (position_nxt),
    .frame_direction_nxt (frame_dir_nxt),
    .frame_length_nxt    (frame_len_nxt),
    .running_xor_nxt     (run_xor_nxt),
    .result              (result_nxt)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      frame_dir_r <= 1'b0;
      frame_len_r <= '0;
      run_xor_r   <= '0;
    end else if (in_fire) begin
      position_r  <= position_nxt;
      frame_dir_r <= frame_dir_nxt;
      frame_len_r <= frame_len_nxt;
      run_xor_r   <= run_xor_nxt;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_class     = result_r.byte_class;
  assign out_byte_direction = result_r.byte_direction;
  assign out_byte_echo      = result_r.byte_echo;
  assign out_frame_offset   = result_r.frame_offset;
  assign out_frame_total    = result_r.frame_total;
  assign out_frame_done     = result_r.frame_done;
  assign out_frame_dropped  = result_r.frame_dropped;

endmodule

### tb/xcfp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfp_frame_checker
// Watches the byte, result and register channels of the frame parser. Keeps
// its own copy of the header registers and frame state, predicts the class
// of every accepted byte and compares each result beat field by field.
// ----------------------------------------------------------------------------
module xcfp_frame_checker #(
  parameter int unsigned MAX_FRAME = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_byte_value,
  input  logic                           in_direction,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [3:0]                     out_byte_class,
  input  logic                           out_byte_direction,
  input  logic [7:0]                     out_byte_echo,
  input  logic [5:0]                     out_frame_offset,
  input  logic [6:0]                     out_frame_total,
  input  logic                           out_frame_done,
  input  logic                           out_frame_dropped,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [xcfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_owed
);

  // header registers as last written
  logic [7:0] req_header;
  logic [7:0] rsp_header;

  // frame tracking: position counts bytes taken, zero while hunting
  logic [6:0] position;
  logic       frame_dir;
  logic [6:0] frame_len;
  logic [7:0] frame_xor;

  xcfp_pkg::result_t predicted_results[$];

  // back to hunting for a header
  function automatic void close_frame();
    position  = '0;
    frame_dir = 1'b0;
    frame_len = '0;
    frame_xor = '0;
  endfunction

  // classify one byte and advance the frame state
  function automatic xcfp_pkg::result_t classify_byte(input logic [7:0] b, input logic d);
    xcfp_pkg::result_t          r;
    logic [xcfp_pkg::LEN_W-1:0] len;
    logic [7:0]                 hdr;
    r                = '0;
    r.byte_class     = xcfp_pkg::CLS_IGNORED;
    r.byte_direction = d;
    r.byte_echo      = b;

    // same line continues the frame, the other line abandons it
    if (position != 0) begin
      if (frame_dir == d) begin
        position  = position + 7'd1;
        frame_xor = frame_xor ^ b;
      end else begin
        close_frame();
        r.frame_dropped = 1'b1;
      end
    end

    if (position == 0) begin
      // hunting: only this line's header opens a frame
      hdr = d ? req_header : rsp_header;
      if (b == hdr) begin
        position     = 7'd1;
        frame_dir    = d;
        frame_xor    = b;
        r.byte_class = xcfp_pkg::CLS_HEADER;
      end
    end else begin
      r.frame_offset = 6'(position - 7'd1);
      if (position == 7'd2) begin
        // size byte, oversize frames are rejected right here
        len = xcfp_pkg::LEN_W'(xcfp_pkg::MIN_FRAME) + xcfp_pkg::LEN_W'(b);
        if (len > MAX_FRAME) begin
          r.byte_class = xcfp_pkg::CLS_SIZE_ERR;
          r.frame_done = 1'b1;
          close_frame();
        end else begin
          frame_len     = 7'(len);
          r.byte_class  = xcfp_pkg::CLS_SIZE;
          r.frame_total = 7'(len);
        end
      end else begin
        r.frame_total = frame_len;
        if (position == frame_len) begin
          r.byte_class = (frame_xor == 8'd0) ? xcfp_pkg::CLS_CS_GOOD
                                             : xcfp_pkg::CLS_CS_BAD;
          r.frame_done = 1'b1;
          close_frame();
        end else if (position == 7'd3) begin
          r.byte_class = d ? xcfp_pkg::CLS_COMMAND : xcfp_pkg::CLS_ANSWER;
        end else begin
          r.byte_class = xcfp_pkg::CLS_PAYLOAD;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // channel monitor, sampled at the clock edge
  always @(posedge clk) begin
    xcfp_pkg::result_t want;
    if (!rst_n) begin
      req_header = xcfp_pkg::REQUEST_HEADER_RST;
      rsp_header = xcfp_pkg::RESPONSE_HEADER_RST;
      close_frame();
      predicted_results.delete();
      mismatch_count = 0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          xcfp_pkg::REG_REQUEST_HEADER: begin
            req_header = cfg_data;
          end
          xcfp_pkg::REG_RESPONSE_HEADER: begin
            rsp_header = cfg_data;
          end
          default: begin
          end
        endcase
      end

      // result beats against the oldest prediction
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result beat 0x%02h with no byte outstanding", out_byte_echo);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_class", want.byte_class, out_byte_class);
          check_field("byte_direction", want.byte_direction, out_byte_direction);
          check_field("byte_echo", want.byte_echo, out_byte_echo);
          check_field("frame_offset", want.frame_offset, out_frame_offset);
          check_field("frame_total", want.frame_total, out_frame_total);
          check_field("frame_done", want.frame_done, out_frame_done);
          check_field("frame_dropped", want.frame_dropped, out_frame_dropped);
        end
      end

      // accepted byte beats
      if (in_valid && in_ready) begin
        predicted_results.push_back(classify_byte(in_byte_value, in_direction));
      end
    end
    results_owed = predicted_results.size();
  end

endmodule

### tb/xor_checksum_frame_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checksum_frame_parser_core_tb
// Drives tagged serial bytes and header register writes into the frame
// parser: a directed set of corner frames, then mostly well-formed random
// frames mixed with oversize, truncated and noise traffic, over several
// header settings, with random stalls on both sides except in one phase.
// ----------------------------------------------------------------------------
module xor_checksum_frame_parser_core_tb;

  localparam int unsigned FRAME_MAX      = 64;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned PHASE_COUNT    = 6;
  localparam int unsigned BEATS_PER_PHASE = 325;
  localparam logic        DIR_RESPONSE   = 1'b0;
  localparam logic        DIR_REQUEST    = 1'b1;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [7:0]                     in_byte_value;
  logic                           in_direction;
  logic                           out_valid;
  logic                           out_ready;
  logic [3:0]                     out_byte_class;
  logic                           out_byte_direction;
  logic [7:0]                     out_byte_echo;
  logic [5:0]                     out_frame_offset;
  logic [6:0]                     out_frame_total;
  logic                           out_frame_done;
  logic                           out_frame_dropped;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [xcfp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                     cfg_data;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned beats_sent;
  int unsigned cycle_count;
  bit          stalls_on;
  logic [7:0]  req_header;
  logic [7:0]  rsp_header;

  xor_checksum_frame_parser_core #(
    .MAX_FRAME(FRAME_MAX)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_direction      (in_direction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_class    (out_byte_class),
    .out_byte_direction(out_byte_direction),
    .out_byte_echo     (out_byte_echo),
    .out_frame_offset  (out_frame_offset),
    .out_frame_total   (out_frame_total),
    .out_frame_done    (out_frame_done),
    .out_frame_dropped (out_frame_dropped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  xcfp_frame_checker #(
    .MAX_FRAME(FRAME_MAX)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte_value     (in_byte_value),
    .in_direction      (in_direction),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte_class    (out_byte_class),
    .out_byte_direction(out_byte_direction),
    .out_byte_echo     (out_byte_echo),
    .out_frame_offset  (out_frame_offset),
    .out_frame_total   (out_frame_total),
    .out_frame_done    (out_frame_done),
    .out_frame_dropped (out_frame_dropped),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= stalls_on ? ($urandom_range(0, 99) >= 26) : 1'b1;
  end

  // one byte beat, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] b, input logic d);
    bit taken;
    if (stalls_on) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_direction  <= d;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  // frame of 4 + size bytes, cut short after n_send bytes
  task automatic send_frame(input logic d, input int unsigned size, input bit bad_cs,
                            input int unsigned n_send);
    int unsigned flen;
    int unsigned i;
    logic [7:0]  fxor;
    logic [7:0]  b;
    flen = xcfp_pkg::MIN_FRAME + size;
    fxor = 8'd0;
    for (i = 0; i < flen && i < n_send; i++) begin
      if (i == 0) begin
        b = d ? req_header : rsp_header;
      end else if (i == 1) begin
        b = size[7:0];
      end else if (i == flen - 1) begin
        b = bad_cs ? (fxor ^ 8'($urandom_range(1, 255))) : fxor;
      end else begin
        b = 8'($urandom);
      end
      fxor ^= b;
      send_beat(b, d);
    end
  endtask

  task automatic write_reg(input logic [xcfp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] value);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait for every result beat
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    @(posedge clk);
  endtask

  // mostly good frames, plus oversize, truncated and noise traffic
  task automatic random_traffic(input int unsigned n_beats);
    int unsigned target;
    int unsigned pick;
    int unsigned size;
    int unsigned k;
    logic        d;
    target = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      d    = 1'($urandom);
      if (pick < 70) begin
        k = $urandom_range(0, 99);
        if (k < 85) size = $urandom_range(0, 6);
        else if (k < 95) size = $urandom_range(7, 59);
        else size = FRAME_MAX - xcfp_pkg::MIN_FRAME;
        send_frame(d, size, $urandom_range(0, 99) < 15, xcfp_pkg::MIN_FRAME + size);
      end else if (pick < 78) begin
        size = ($urandom_range(0, 9) == 0) ? FRAME_MAX - xcfp_pkg::MIN_FRAME + 1
                                           : $urandom_range(61, 255);
        send_frame(d, size, 1'b0, 2);
      end else if (pick < 88) begin
        // frame cut off by a byte on the other line
        size = $urandom_range(0, 6);
        send_frame(d, size, 1'b0, $urandom_range(1, xcfp_pkg::MIN_FRAME + size - 1));
        if ($urandom_range(0, 1) == 0) send_beat(d ? rsp_header : req_header, ~d);
        else send_beat(8'($urandom), ~d);
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) send_beat(8'($urandom), 1'($urandom));
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    logic [7:0]  req_list[PHASE_COUNT];
    logic [7:0]  rsp_list[PHASE_COUNT];
    int unsigned ph;
    req_list = '{8'hD9, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'hD9};
    rsp_list = '{8'h9D, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h9D};
    stalls_on     = 1'b1;
    beats_sent    = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_byte_value <= 8'd0;
    in_direction  <= 1'b0;
    out_ready     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= xcfp_pkg::REG_REQUEST_HEADER;
    cfg_data      <= 8'd0;
    req_header    = xcfp_pkg::REQUEST_HEADER_RST;
    rsp_header    = xcfp_pkg::RESPONSE_HEADER_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle bytes, including a header on the wrong line
    send_beat(8'h00, DIR_RESPONSE);
    send_beat(8'hFF, DIR_REQUEST);
    send_beat(xcfp_pkg::RESPONSE_HEADER_RST, DIR_REQUEST);
    // zero size request, good checksum
    send_frame(DIR_REQUEST, 0, 1'b0, xcfp_pkg::MIN_FRAME);
    // one payload byte response, bad checksum
    send_frame(DIR_RESPONSE, 1, 1'b1, xcfp_pkg::MIN_FRAME + 1);
    // oversize: just past the limit and the largest size byte
    send_frame(DIR_REQUEST, FRAME_MAX - xcfp_pkg::MIN_FRAME + 1, 1'b0, 2);
    send_frame(DIR_RESPONSE, 255, 1'b0, 2);
    // direction change: abandoning byte opens a new frame, then a plain one
    send_frame(DIR_REQUEST, 2, 1'b0, 3);
    send_beat(xcfp_pkg::RESPONSE_HEADER_RST, DIR_RESPONSE);
    send_beat(8'h03, DIR_RESPONSE);
    send_beat(8'hA5, DIR_REQUEST);
    drain();

    // random traffic over several header settings
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      if (ph != 0) begin
        req_header = (ph == 4) ? 8'($urandom) : req_list[ph];
        rsp_header = (ph == 4) ? 8'($urandom) : rsp_list[ph];
        write_reg(xcfp_pkg::REG_REQUEST_HEADER, req_header);
        write_reg(xcfp_pkg::REG_RESPONSE_HEADER, rsp_header);
      end
      stalls_on = (ph != 3);
      random_traffic(BEATS_PER_PHASE);
      drain();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
